// File: design/vcps_pkg.sv
// Shared types, constants and the arctangent table for the velocity command converter.
// No dependencies.
package vcps_pkg;

  localparam int unsigned FracBits       = 10;
  localparam int unsigned AtanIterations = 14;
  localparam int unsigned AtanTableLen   = 20;
  localparam int unsigned QuotBits       = 12;   // divider stages, one quotient bit each

  localparam int unsigned OneQ      = 1 << FracBits;
  localparam int unsigned KTenth    = (OneQ + 5) / 10;
  localparam int unsigned KHundredth = (OneQ + 50) / 100;
  localparam int unsigned KFifth    = (2 * OneQ + 5) / 10;
  localparam int unsigned KHalf     = OneQ / 2;
  localparam int unsigned KWheelbase = (27 * OneQ + 5) / 10;

  localparam int unsigned XyW   = 30;  // CORDIC x/y datapath
  localparam int unsigned ZW    = 32;  // CORDIC angle, Q.30
  localparam int unsigned AngW  = 36;  // angle with small-speed branch
  localparam int unsigned DenW  = 22;

  typedef enum logic [2:0] {
    RegMaxSteer   = 3'd0,
    RegThrGain    = 3'd1,
    RegBrkGain    = 3'd2,
    RegSpeedTol   = 3'd3,
    RegSteerDb    = 3'd4,
    RegThrDb      = 3'd5,
    RegBrkDb      = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    GearNeutral = 2'd0,
    GearForward = 2'd1,
    GearReverse = 2'd2
  } gear_e;

  typedef struct packed {
    logic                   use_cordic;
    logic signed [AngW-1:0] small_ang;
  } steer_side_t;

  typedef struct packed {
    logic neg;
    logic zero;
  } div_side_t;

  typedef struct packed {
    logic [11:0] thr_gain;
    logic [11:0] brk_gain;
    logic [11:0] speed_tol;
    logic [10:0] thr_db;
    logic [10:0] brk_db;
  } pedal_cfg_t;

  typedef struct packed {
    logic [10:0] thr;
    logic [10:0] brk;
    gear_e       gear;
  } pedal_res_t;

  function automatic logic [ZW-1:0] atan_q30(input int unsigned i);
    logic [ZW-1:0] t;
    case (i)
      0:  t = 32'd843314856;
      1:  t = 32'd497837829;
      2:  t = 32'd263043836;
      3:  t = 32'd133525158;
      4:  t = 32'd67021686;
      5:  t = 32'd33543515;
      6:  t = 32'd16775850;
      7:  t = 32'd8388437;
      8:  t = 32'd4194282;
      9:  t = 32'd2097149;
      10: t = 32'd1048575;
      11: t = 32'd524287;
      12: t = 32'd262143;
      13: t = 32'd131071;
      14: t = 32'd65535;
      15: t = 32'd32767;
      16: t = 32'd16383;
      17: t = 32'd8191;
      18: t = 32'd4095;
      default: t = 32'd2047;
    endcase
    return t;
  endfunction

endpackage

// File: design/vcps_cordic.sv
// Pipelined CORDIC vectoring unit, one iteration per register stage.
// Depends on vcps_pkg.
module vcps_cordic #(
  parameter int unsigned Iter = vcps_pkg::AtanIterations
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [vcps_pkg::XyW-1:0]   x_i,
  input  logic signed [vcps_pkg::XyW-1:0]   y_i,
  input  vcps_pkg::steer_side_t             side_i,
  output logic                              valid_o,
  output logic signed [vcps_pkg::ZW-1:0]    z_o,
  output vcps_pkg::steer_side_t             side_o
);
  import vcps_pkg::*;

  logic                v_q    [Iter+1];
  logic signed [XyW-1:0] x_q  [Iter+1];
  logic signed [XyW-1:0] y_q  [Iter+1];
  logic signed [ZW-1:0]  z_q  [Iter+1];
  steer_side_t         side_q [Iter+1];

  assign v_q[0]    = valid_i;
  assign x_q[0]    = x_i;
  assign y_q[0]    = y_i;
  assign z_q[0]    = '0;
  assign side_q[0] = side_i;

  for (genvar i = 0; i < Iter; i++) begin : g_iter
    logic signed [XyW-1:0] xs, ys, x_d, y_d;
    logic signed [ZW-1:0]  z_d;
    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;
    always_comb begin
      if (!y_q[i][XyW-1]) begin
        x_d = x_q[i] + ys;
        y_d = y_q[i] - xs;
        z_d = z_q[i] + $signed(atan_q30(i));
      end else begin
        x_d = x_q[i] - ys;
        y_d = y_q[i] + xs;
        z_d = z_q[i] - $signed(atan_q30(i));
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        z_q[i+1]    <= z_d;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = v_q[Iter];
  assign z_o     = z_q[Iter];
  assign side_o  = side_q[Iter];

endmodule

// File: design/vcps_div.sv
// Pipelined restoring divider with saturation to one, one quotient bit per stage.
// Depends on vcps_pkg.
module vcps_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         valid_i,
  input  logic [vcps_pkg::AngW-1:0]    num_i,
  input  logic [vcps_pkg::DenW-1:0]    den_i,
  input  vcps_pkg::div_side_t          side_i,
  output logic                         valid_o,
  output logic [vcps_pkg::FracBits:0]  quot_o,
  output vcps_pkg::div_side_t          side_o
);
  import vcps_pkg::*;

  localparam int unsigned RemW = AngW + 1;

  logic                v_q    [QuotBits+1];
  logic [RemW-1:0]     rem_q  [QuotBits+1];
  logic [DenW-1:0]     den_q  [QuotBits+1];
  logic [QuotBits-1:0] quo_q  [QuotBits+1];
  logic                ovf_q  [QuotBits+1];
  div_side_t           side_q [QuotBits+1];

  assign v_q[0]    = valid_i;
  assign rem_q[0]  = {1'b0, num_i};
  assign den_q[0]  = den_i;
  assign quo_q[0]  = '0;
  assign side_q[0] = side_i;
  // quotient of QuotBits+1 bits or more saturates anyway
  assign ovf_q[0]  = ({1'b0, num_i} >= ({{(RemW-DenW){1'b0}}, den_i} << QuotBits));

  for (genvar k = 0; k < QuotBits; k++) begin : g_bit
    localparam int unsigned Sh = QuotBits - 1 - k;
    logic [RemW-1:0] dsh;
    logic            ge;
    assign dsh = {{(RemW-DenW){1'b0}}, den_q[k]} << Sh;
    assign ge  = rem_q[k] >= dsh;
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (en_i) begin
        v_q[k+1] <= v_q[k];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1]  <= ge ? rem_q[k] - dsh : rem_q[k];
        quo_q[k+1]  <= quo_q[k] | (QuotBits'(ge) << Sh);
        den_q[k+1]  <= den_q[k];
        ovf_q[k+1]  <= ovf_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  always_comb begin
    if (ovf_q[QuotBits] || quo_q[QuotBits] > QuotBits'(OneQ)) begin
      quot_o = (FracBits+1)'(OneQ);
    end else begin
      quot_o = quo_q[QuotBits][FracBits:0];
    end
  end

  assign valid_o = v_q[QuotBits];
  assign side_o  = side_q[QuotBits];

endmodule

// File: design/vcps_pedal.sv
// Gear, throttle and brake: registered products, then registered pedal decision.
// Depends on vcps_pkg.
module vcps_pedal (
  input  logic                clk_i,
  input  logic                en_i,
  input  vcps_pkg::pedal_cfg_t cfg_i,
  input  logic signed [15:0]  ts_i,
  input  logic signed [15:0]  ms_i,
  output vcps_pkg::pedal_res_t res_o
);
  import vcps_pkg::*;

  typedef enum logic [1:0] {
    ModeStop,
    ModeReversal,
    ModeDrive
  } mode_e;

  logic signed [16:0] err;
  logic signed [17:0] e_d;
  logic [16:0]        ts_abs, ms_abs, err_abs;
  logic               rev_d;
  mode_e              mode_d;
  gear_e              gear_d;

  mode_e              mode_q;
  gear_e              gear_q;
  logic signed [17:0] e_q;
  logic [16:0]        err_abs_q;
  logic               slow_q;
  logic signed [30:0] pt_q;
  logic [28:0]        pb_q, pr_q;
  logic [16:0]        stop_b_q;

  assign err     = 17'(ts_i) - 17'(ms_i);
  assign ts_abs  = ts_i[15] ? 17'(-17'(ts_i)) : 17'(ts_i);
  assign ms_abs  = ms_i[15] ? 17'(-17'(ms_i)) : 17'(ms_i);
  assign err_abs = err[16] ? 17'(-err) : 17'(err);

  always_comb begin
    rev_d = 1'b0;
    if (ts_abs <= 17'(KHundredth)) begin
      mode_d = ModeStop;
      gear_d = GearNeutral;
      e_d    = 18'(err);
    end else if (!ts_i[15]) begin
      gear_d = GearForward;
      rev_d  = $signed(17'(ms_i)) < -$signed(17'(KHundredth));
      mode_d = rev_d ? ModeReversal : ModeDrive;
      e_d    = 18'(err);
    end else begin
      gear_d = GearReverse;
      rev_d  = $signed(17'(ms_i)) > $signed(17'(KHundredth));
      mode_d = rev_d ? ModeReversal : ModeDrive;
      e_d    = -18'(err);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mode_q    <= mode_d;
      gear_q    <= gear_d;
      e_q       <= e_d;
      err_abs_q <= err_abs;
      slow_q    <= ms_abs < 17'(KTenth);
      pt_q      <= $signed({1'b0, cfg_i.thr_gain}) * e_d;
      pb_q      <= cfg_i.brk_gain * err_abs;
      pr_q      <= cfg_i.brk_gain * ms_abs;
      stop_b_q  <= (ms_abs >> 1) + 17'(KTenth);
    end
  end

  logic signed [21:0] tv;
  logic [18:0]        bn;
  logic [19:0]        br;
  logic [16:0]        bs;
  pedal_res_t         res_d;

  always_comb begin
    res_d.gear = gear_q;
    res_d.thr  = '0;
    res_d.brk  = '0;
    tv = '0;
    bn = pb_q[28:FracBits];
    br = 20'(pr_q[28:FracBits]) + 20'(KFifth);
    bs = stop_b_q;
    case (mode_q)
      ModeStop: begin
        if (bs > 17'(KHalf)) bs = 17'(KHalf);
        if (bs < 17'(cfg_i.brk_db)) bs = 17'(cfg_i.brk_db);
        res_d.brk = (bs > 17'(OneQ)) ? 11'(OneQ) : bs[10:0];
      end
      ModeReversal: begin
        res_d.brk = (br > 20'(OneQ)) ? 11'(OneQ) : br[10:0];
      end
      ModeDrive: begin
        if (err_abs_q > 17'(cfg_i.speed_tol)) begin
          tv = 22'(pt_q >>> FracBits);
          if (tv > $signed(22'(OneQ))) tv = 22'(OneQ);
          if (slow_q && e_q > 0) tv = tv + 22'(KTenth);
        end
        if (tv > 0 && tv < $signed({11'd0, cfg_i.thr_db})) tv = {11'd0, cfg_i.thr_db};
        if (e_q > 0) begin
          res_d.thr = (tv > $signed(22'(OneQ))) ? 11'(OneQ) : tv[10:0];
        end else begin
          res_d.brk = (bn > 19'(OneQ)) ? 11'(OneQ) : bn[10:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o <= res_d;
    end
  end

endmodule

// File: design/velocity_cmd_to_pedal_steer.sv
// Top level: velocity command to steering, throttle, brake and gear.
// Depends on vcps_pkg, vcps_cordic, vcps_div, vcps_pedal.
//
//  channel | signals                                          | direction
//  --------+--------------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, target_speed_i,           | sink
//          | target_yaw_rate_i, measured_speed_i              |
//  out     | out_valid_o/out_ready_i, steer_out_o,            | source
//          | throttle_out_o, brake_out_o, gear_out_o          |
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i | sink
//
// One transfer per cycle sustained. From input transfer to output valid a command
// passes the prep stage, one CORDIC stage per iteration, the angle stage, twelve
// divider stages and the output register. Pedal logic runs in two stages and
// rides a delay line alongside.
// The whole pipeline advances together; it holds only while the output register
// is full and not taken. Reset clears valid bits and loads register defaults.
module velocity_cmd_to_pedal_steer #(
  parameter int unsigned AtanIterations = vcps_pkg::AtanIterations
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic signed [15:0] target_speed_i,
  input  logic signed [15:0] target_yaw_rate_i,
  input  logic signed [15:0] measured_speed_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic signed [11:0] steer_out_o,
  output logic [10:0] throttle_out_o,
  output logic [10:0] brake_out_o,
  output logic [1:0]  gear_out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  import vcps_pkg::*;

  // pedal result comes out of 2 stages; steering quotient out of the prep, CORDIC, angle and divider stages
  localparam int unsigned PedDly = AtanIterations + 12;

  // configuration registers
  logic [11:0] max_steer_q;
  logic [9:0]  steer_db_q;
  pedal_cfg_t  pcfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_steer_q      <= 12'd717;
      pcfg_q.thr_gain  <= 12'd512;
      pcfg_q.brk_gain  <= 12'd512;
      pcfg_q.speed_tol <= 12'd102;
      steer_db_q       <= 10'd10;
      pcfg_q.thr_db    <= 11'd51;
      pcfg_q.brk_db    <= 11'd51;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegMaxSteer: max_steer_q      <= cfg_data_i;
        RegThrGain:  pcfg_q.thr_gain  <= cfg_data_i;
        RegBrkGain:  pcfg_q.brk_gain  <= cfg_data_i;
        RegSpeedTol: pcfg_q.speed_tol <= cfg_data_i;
        RegSteerDb:  steer_db_q       <= cfg_data_i[9:0];
        RegThrDb:    pcfg_q.thr_db    <= cfg_data_i[10:0];
        RegBrkDb:    pcfg_q.brk_db    <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // global advance: move unless a finished result is stalled
  logic en;
  logic in_xfer;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;
  assign in_xfer    = in_valid_i && en;

  // prep stage: CORDIC start vector and low-speed angle
  logic [16:0]           ms_abs;
  logic                  prep_v_q;
  logic signed [XyW-1:0] x0_q, y0_q;
  steer_side_t           prep_side_q;

  assign ms_abs = measured_speed_i[15] ? 17'(-17'(measured_speed_i))
                                       : 17'(measured_speed_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (en) begin
      prep_v_q <= in_xfer;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= XyW'({ms_abs, FracBits'(0)});
      // 2.7 * yaw in Q.20 fits well inside the CORDIC width
      y0_q <= XyW'(target_yaw_rate_i * $signed({1'b0, 12'(KWheelbase)}));
      prep_side_q.use_cordic <= ms_abs > 17'(KTenth);
      // yaw / 2 moved to Q.30
      prep_side_q.small_ang  <= AngW'(target_yaw_rate_i) <<< (29 - FracBits);
    end
  end

  // CORDIC
  logic                 cor_v;
  logic signed [ZW-1:0] cor_z;
  steer_side_t          cor_side;

  vcps_cordic #(.Iter(AtanIterations)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (prep_v_q),
    .x_i     (x0_q),
    .y_i     (y0_q),
    .side_i  (prep_side_q),
    .valid_o (cor_v),
    .z_o     (cor_z),
    .side_o  (cor_side)
  );

  // angle stage: pick branch, deadband, form rounded-division operands
  logic signed [AngW-1:0] ang;
  logic [AngW-1:0]        mag;
  logic                   ang_v_q;
  logic [AngW-1:0]        num_q;
  logic [DenW-1:0]        den_q;
  div_side_t              ang_side_q;

  assign ang = cor_side.use_cordic ? AngW'(cor_z) : cor_side.small_ang;
  assign mag = ang[AngW-1] ? AngW'(-ang) : AngW'(ang);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_v_q <= 1'b0;
    end else if (en) begin
      ang_v_q <= cor_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // (mag*2^F + den/2) / den reduces to (mag + msa*2^(29-2F)) / (msa*2^(30-2F))
      num_q <= mag + (AngW'(max_steer_q) << (30 - 2 * FracBits - 1));
      den_q <= DenW'(max_steer_q) << (30 - 2 * FracBits);
      ang_side_q.neg  <= ang[AngW-1];
      ang_side_q.zero <= mag < (AngW'(steer_db_q) << (30 - FracBits));
    end
  end

  // normalize: divide by max steer angle, saturate to one
  logic                div_v;
  logic [FracBits:0]   quot;
  div_side_t           div_side;

  vcps_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ang_v_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .side_i  (ang_side_q),
    .valid_o (div_v),
    .quot_o  (quot),
    .side_o  (div_side)
  );

  // pedals and gear
  pedal_res_t ped;
  pedal_res_t ped_dly_q [PedDly];

  vcps_pedal u_pedal (
    .clk_i (clk_i),
    .en_i  (en),
    .cfg_i (pcfg_q),
    .ts_i  (target_speed_i),
    .ms_i  (measured_speed_i),
    .res_o (ped)
  );

  always_ff @(posedge clk_i) begin
    if (en) begin
      ped_dly_q[0] <= ped;
      for (int unsigned i = 1; i < PedDly; i++) begin
        ped_dly_q[i] <= ped_dly_q[i-1];
      end
    end
  end

  // output register
  logic signed [11:0] steer_d;
  logic               out_v_q;
  logic signed [11:0] steer_q;
  pedal_res_t         res_q;

  always_comb begin
    if (div_side.zero) begin
      steer_d = '0;
    end else if (div_side.neg) begin
      steer_d = -$signed(12'(quot));
    end else begin
      steer_d = $signed(12'(quot));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= div_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      steer_q <= steer_d;
      res_q   <= ped_dly_q[PedDly-1];
    end
  end

  assign out_valid_o    = out_v_q;
  assign steer_out_o    = steer_q;
  assign throttle_out_o = res_q.thr;
  assign brake_out_o    = res_q.brk;
  assign gear_out_o     = res_q.gear;

endmodule

// File: tb/sv/velocity_cmd_to_pedal_steer_tb.sv
// Self-checking testbench for velocity_cmd_to_pedal_steer: random and directed commands,
// an internal pedal/steering predictor and an in-order result scoreboard.
// Depends on vcps_pkg and the RTL of velocity_cmd_to_pedal_steer.
`timescale 1ns / 100ps

module velocity_cmd_to_pedal_steer_tb;
  import vcps_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 45;   // more than the pipeline depth, prep stage to output register

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [15:0] target_speed_i = '0;
  logic signed [15:0] target_yaw_rate_i = '0;
  logic signed [15:0] measured_speed_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [11:0] steer_out_o;
  logic [10:0]        throttle_out_o;
  logic [10:0]        brake_out_o;
  logic [1:0]         gear_out_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [11:0]        cfg_data_i = '0;

  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;

  velocity_cmd_to_pedal_steer dut (.*);

  always #1 clk_i = ~clk_i;

  typedef struct {
    logic [11:0] steer;
    logic [10:0] thr;
    logic [10:0] brk;
    gear_e       gear;
  } pedal_steer_t;

  // Predicts pedal, steering and gear for each command transfer and checks
  // results against them in arrival order.
  class pedal_scoreboard;
    pedal_steer_t expq[$];
    int unsigned  errors = 0;
    longint max_steer, thr_gain, brk_gain, speed_tol, steer_db, thr_db, brk_db;

    function new();
      max_steer = 717; thr_gain = 512; brk_gain = 512; speed_tol = 102;
      steer_db = 10; thr_db = 51; brk_db = 51;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [11:0] d);
      case (idx)
        RegMaxSteer: max_steer = d;
        RegThrGain:  thr_gain  = d;
        RegBrkGain:  brk_gain  = d;
        RegSpeedTol: speed_tol = d;
        RegSteerDb:  steer_db  = d[9:0];
        RegThrDb:    thr_db    = d[10:0];
        RegBrkDb:    brk_db    = d[10:0];
        default: ;
      endcase
    endfunction

    function longint abs_l(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint sat_unit(longint v);
      return v < 0 ? 0 : (v > OneQ ? OneQ : v);
    endfunction

    // CORDIC vectoring, angle in Q.30; >>> on signed longint floors
    function longint atan_vec(longint y, longint x);
      longint z, xs, ys;
      z = 0;
      for (int i = 0; i < AtanIterations; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z += longint'(atan_q30(i));
        end else begin
          x = x - ys; y = y + xs; z -= longint'(atan_q30(i));
        end
      end
      return z;
    endfunction

    function longint steer_angle(longint yaw, longint ms);
      longint ang, mag, q, num, den;
      if (abs_l(ms) > KTenth) ang = atan_vec(yaw * KWheelbase, abs_l(ms) * OneQ);
      else ang = yaw <<< (29 - FracBits);
      mag = abs_l(ang);
      if (mag < (steer_db <<< (30 - FracBits))) return 0;
      if (max_steer == 0) q = OneQ;
      else begin
        num = mag <<< FracBits;
        den = max_steer <<< (30 - FracBits);
        q = (num + den / 2) / den;
        if (q > OneQ) q = OneQ;
      end
      return ang < 0 ? -q : q;
    endfunction

    // normal drive: err already negated in reverse
    function void drive_pedals(longint err, longint err_abs, longint ms,
                               output longint thr, output longint brk);
      longint tv;
      tv = 0;
      if (err_abs > speed_tol) begin
        tv = (thr_gain * err) >>> FracBits;
        if (tv > OneQ) tv = OneQ;
        if (abs_l(ms) < KTenth && err > 0) tv += KTenth;   // standstill boost
      end
      if (tv > 0 && tv < thr_db) tv = thr_db;
      if (err > 0) begin
        thr = sat_unit(tv); brk = 0;
      end else begin
        thr = 0; brk = sat_unit((brk_gain * err_abs) >>> FracBits);
      end
    endfunction

    function void note_command(logic signed [15:0] ts_i, logic signed [15:0] yaw_i,
                               logic signed [15:0] ms_i);
      longint ts, yaw, ms, err, thr, brk, b;
      pedal_steer_t r;
      ts = ts_i; yaw = yaw_i; ms = ms_i;
      err = ts - ms;
      thr = 0; brk = 0;
      if (abs_l(ts) <= KHundredth) begin
        // stop command, both ends of the window included
        b = (abs_l(ms) >>> 1) + KTenth;
        if (b > KHalf) b = KHalf;
        if (b < brk_db) b = brk_db;
        r.gear = GearNeutral;
        brk = sat_unit(b);
      end else if (ts > 0) begin
        r.gear = GearForward;
        if (ms < -longint'(KHundredth)) brk = reversal(ms);
        else drive_pedals(err, abs_l(err), ms, thr, brk);
      end else begin
        r.gear = GearReverse;
        if (ms > longint'(KHundredth)) brk = reversal(ms);
        else drive_pedals(-err, abs_l(err), ms, thr, brk);
      end
      r.steer = 12'(steer_angle(yaw, ms));
      r.thr = 11'(thr);
      r.brk = 11'(brk);
      expq.push_back(r);
    endfunction

    function longint reversal(longint ms);
      longint b;
      b = ((brk_gain * abs_l(ms)) >>> FracBits) + KFifth;
      return b > OneQ ? OneQ : b;
    endfunction

    function void report(string what, longint got, longint want);
      $display("MISMATCH t=%0t %s: got %0d expected %0d", $time, what, got, want);
      errors++;
    endfunction

    function void check_result(logic [11:0] st, logic [10:0] th, logic [10:0] br,
                               logic [1:0] gr);
      pedal_steer_t e;
      if (expq.size() == 0) begin
        report("unexpected result transfer", 1, 0);
        return;
      end
      e = expq.pop_front();
      if (st !== e.steer) report("steer", $signed(st), $signed(e.steer));
      if (th !== e.thr)   report("throttle", th, e.thr);
      if (br !== e.brk)   report("brake", br, e.brk);
      if (gr !== e.gear)  report("gear", gr, e.gear);
    endfunction
  endclass

  pedal_scoreboard sb = new();

  // result side: ready changes on the falling edge, transfers sampled on the rising edge
  initial forever begin
    @(negedge clk_i);
    out_ready_i = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(steer_out_o, throttle_out_o, brake_out_o, gear_out_o);
      results_seen++;
    end
  end

  // watchdog: cycles without any transfer on any channel
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Timeout: no transfer for %0d cycles", WatchdogLimit);
      $display("Verification failed");
      $finish;
    end
  end

  // one command transfer; valid stays up after it until the next falling edge
  task automatic send_cmd(logic signed [15:0] ts, logic signed [15:0] yaw,
                          logic signed [15:0] ms);
    @(negedge clk_i);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    target_speed_i = ts;
    target_yaw_rate_i = yaw;
    measured_speed_i = ms;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_command(ts, yaw, ms);
    items_sent++;
  endtask

  // drop valid and let every outstanding result come back before a register write
  task automatic drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expq.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [11:0] d);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = d;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, d);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic write_all(int unsigned ms_a, int unsigned tg, int unsigned bg,
                           int unsigned tol, int unsigned sdb, int unsigned tdb,
                           int unsigned bdb);
    write_reg(RegMaxSteer, 12'(ms_a));
    write_reg(RegThrGain, 12'(tg));
    write_reg(RegBrkGain, 12'(bg));
    write_reg(RegSpeedTol, 12'(tol));
    write_reg(RegSteerDb, 12'(sdb));
    write_reg(RegThrDb, 12'(tdb));
    write_reg(RegBrkDb, 12'(bdb));
  endtask

  // speed values: mostly realistic, with weight on the stop and low-speed
  // thresholds, and some fully random words so every bit toggles
  function automatic logic signed [15:0] pick_speed();
    int unsigned k;
    int signed edges[10] = '{10, -10, 11, -11, 102, -102, 103, -103, 0, 9};
    k = $urandom_range(9);
    if (k < 4) return 16'($signed($urandom_range(6000)) - 3000);
    if (k < 6) return 16'($signed($urandom_range(400)) - 200);
    if (k < 8) return 16'(edges[$urandom_range(9)]);
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] pick_yaw();
    int unsigned k;
    k = $urandom_range(9);
    if (k < 5) return 16'($signed($urandom_range(3000)) - 1500);
    if (k < 7) return 16'($signed($urandom_range(60)) - 30);
    return 16'($urandom);
  endfunction

  task automatic random_phase(int unsigned n);
    int unsigned base_idle;
    base_idle = sender_idle_pct;
    for (int unsigned i = 0; i < n; i++) begin
      send_cmd(pick_speed(), pick_yaw(), pick_speed());
      // short runs with no idling now and then
      if ($urandom_range(15) == 0) begin
        sender_idle_pct = ($urandom_range(1) == 0) ? 0 : base_idle;
      end
    end
    sender_idle_pct = base_idle;
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed commands at reset register values
    send_cmd(0, 0, 0);
    send_cmd(10, 0, 0);                 // stop window, positive end
    send_cmd(-10, 100, 400);            // stop window, negative end
    send_cmd(11, 0, 0);                 // just outside stop, inside speed tolerance, no throttle
    send_cmd(-11, 0, 0);
    send_cmd(32767, 32767, 32767);
    send_cmd(-32768, -32768, -32768);
    send_cmd(32767, -32768, -32768);    // forward while rolling back
    send_cmd(-32768, 32767, 32767);     // reverse while rolling forward
    send_cmd(500, 200, -500);
    send_cmd(-500, -200, 500);
    send_cmd(500, 300, -10);            // reversal threshold, not taken
    send_cmd(500, 300, -11);
    send_cmd(800, 500, 102);            // low-speed steering branch
    send_cmd(800, 500, 103);            // CORDIC steering branch
    send_cmd(800, -500, -103);
    send_cmd(1000, 3, 500);             // small steering angle, just above deadband
    send_cmd(200, 0, 150);              // within speed tolerance
    send_cmd(500, 0, 1500);             // overspeed, proportional brake
    send_cmd(-1000, 0, -200);           // reverse drive
    send_cmd(-200, 0, -1500);           // reverse, braking
    send_cmd(3000, 1024, 1024);
    send_cmd(50, 0, 0);                 // inside speed tolerance, throttle stays zero
    drain();

    // phase 1: extremes high, no idling
    write_all(4095, 4095, 4095, 4095, 1023, 1024, 1024);
    sender_idle_pct = 0; stall_pct = 0;
    random_phase(130);
    drain();

    // phase 2: extremes low, sender idles
    write_all(1, 0, 0, 0, 0, 0, 0);
    sender_idle_pct = 45; stall_pct = 0;
    random_phase(130);
    drain();

    // phase 3: random registers, receiver stalls
    write_all($urandom_range(4095, 1), $urandom_range(4095), $urandom_range(4095),
              $urandom_range(600), $urandom_range(1023), $urandom_range(1024),
              $urandom_range(1024));
    sender_idle_pct = 0; stall_pct = 45;
    random_phase(130);
    drain();

    // phase 4: back to typical values, both sides idle
    write_all(717, 512, 512, 102, 10, 51, 51);
    sender_idle_pct = 30; stall_pct = 30;
    random_phase(135);
    drain();

    $display("Sent %0d commands over five register settings, %0d results checked",
             items_sent, results_seen);
    $display("Covered stop window, reversal, drive and both steering branches");
    if (sb.errors == 0 && sb.expq.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.expq.size());
      $display("Verification failed");
    end
    $finish;
  end

endmodule
